// ===== design/pua_pkg.sv =====
`default_nettype none
package pua_pkg;

	localparam int SLOTS = 8;
	localparam int USERS = 256;

	localparam int USER_W  = (USERS > 1) ? $clog2(USERS) : 1;
	localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int FILL_W  = $clog2(SLOTS + 1);
	localparam int ADDR_W  = $clog2(USERS * SLOTS);
	localparam int NICE_W  = 8;
	localparam int TAG_W   = 16;
	localparam int ENTRY_W = NICE_W + TAG_W;
	localparam int LIMIT_W = 4;
	localparam int FREE_W  = 4;
	localparam int UID_W   = 8;
	localparam int UID_N   = 1 << UID_W;

	localparam logic [FILL_W-1:0]  SLOTS_F     = FILL_W'(SLOTS);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_TRY    = 2'd1;
	localparam logic [1:0] ACT_RESET  = 2'd2;

	localparam logic [1:0] KIND_USER = 2'd0;
	localparam logic [1:0] KIND_HIGH = 2'd1;

	localparam logic [1:0] STAT_DISPATCH = 2'd0;
	localparam logic [1:0] STAT_QUEUED   = 2'd1;
	localparam logic [1:0] STAT_REJECT   = 2'd2;
	localparam logic [1:0] STAT_CLEARED  = 2'd3;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_FILL,
		S_DECIDE,
		S_SCAN,
		S_EVICT,
		S_DONE
	} pua_state_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [UID_W-1:0]  user_id;
		logic [TAG_W-1:0]  request_id;
		logic [1:0]        request_kind;
		logic [NICE_W-1:0] priority_nice;
	} pua_item_t;

	typedef struct packed {
		logic clr_en;
		logic latch;
		logic fill_cap;
		logic decide;
		logic scan_en;
		logic evict;
		logic load_out;
	} pua_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic need_scan;
		logic scan_done;
		logic out_free;
	} pua_sts_t;

	typedef logic [USER_W-1:0] user_lut_t [UID_N];

	function automatic user_lut_t build_user_lut();
		user_lut_t lut;
		for (int i = 0; i < UID_N; i++) begin
			lut[i] = USER_W'(i % USERS);
		end
		return lut;
	endfunction

	localparam user_lut_t USER_LUT = build_user_lut();

endpackage
`default_nettype wire

// ===== design/pua_req_if.sv =====
`default_nettype none
interface pua_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [7:0]        user_id;
	logic [15:0]       request_id;
	logic [1:0]        request_kind;
	logic signed [7:0] priority_nice;

	modport source (
		output valid, action, user_id, request_id, request_kind, priority_nice,
		input  ready
	);
	modport sink (
		input  valid, action, user_id, request_id, request_kind, priority_nice,
		output ready
	);
endinterface
`default_nettype wire

// ===== design/pua_rsp_if.sv =====
`default_nettype none
interface pua_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        evicted_valid;
	logic [15:0] evicted_request_id;
	logic [3:0]  free_slots;

	modport source (
		output valid, status, evicted_valid, evicted_request_id, free_slots,
		input  ready
	);
	modport sink (
		input  valid, status, evicted_valid, evicted_request_id, free_slots,
		output ready
	);
endinterface
`default_nettype wire

// ===== design/pua_cfg_if.sv =====
`default_nettype none
interface pua_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== design/pua_ram.sv =====
`default_nettype none
module pua_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== design/pua_ctrl.sv =====
`default_nettype none
module pua_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  pua_pkg::pua_sts_t sts,
	output pua_pkg::pua_cmd_t cmd
);
	import pua_pkg::*;

	pua_state_t state_q;
	pua_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) state_d = S_FILL;
			end
			S_FILL:   state_d = S_DECIDE;
			S_DECIDE: state_d = sts.need_scan ? S_SCAN : S_DONE;
			S_SCAN: begin
				if (sts.scan_done) state_d = S_EVICT;
			end
			S_EVICT:  state_d = S_DONE;
			S_DONE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_CLEAR:  cmd.clr_en = 1'b1;
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.latch = req_valid;
			end
			S_FILL:   cmd.fill_cap = 1'b1;
			S_DECIDE: cmd.decide = 1'b1;
			S_SCAN:   cmd.scan_en = 1'b1;
			S_EVICT:  cmd.evict = 1'b1;
			S_DONE:   cmd.load_out = sts.out_free;
			default:  cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

// ===== design/pua_datapath.sv =====
`default_nettype none
module pua_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  pua_pkg::pua_item_t item,
	input  pua_pkg::pua_cmd_t  cmd,
	output pua_pkg::pua_sts_t  sts,
	pua_cfg_if.sink            cfg,
	pua_rsp_if.source          rsp
);
	import pua_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	logic [FILL_W-1:0]  lim_eff;

	logic [1:0]         act_q;
	logic [USER_W-1:0]  user_q;
	logic [TAG_W-1:0]   tag_q;
	logic [1:0]         kind_q;
	logic [NICE_W-1:0]  nice_q;
	logic [FILL_W-1:0]  fill_q;
	logic [ADDR_W-1:0]  base_q;

	logic [USER_W-1:0]  clr_cnt_q;

	logic [FILL_W-1:0]  scan_rd_q;
	logic               cmp_vld_s1;
	logic [SLOT_W-1:0]  cmp_idx_s1;
	logic [SLOT_W-1:0]  worst_idx_q;
	logic [NICE_W-1:0]  worst_nice_q;
	logic [TAG_W-1:0]   worst_tag_q;
	logic               worst_upd;

	logic [1:0]         res_status_q;
	logic               res_ev_q;
	logic [TAG_W-1:0]   res_tag_q;
	logic [FREE_W-1:0]  res_free_q;

	logic               out_vld_q;
	logic [1:0]         out_status_q;
	logic               out_ev_q;
	logic [TAG_W-1:0]   out_tag_q;
	logic [FREE_W-1:0]  out_free_q;

	logic               fill_we;
	logic [USER_W-1:0]  fill_waddr;
	logic [FILL_W-1:0]  fill_wdata;
	logic [FILL_W-1:0]  fill_rdata;

	logic               slot_we;
	logic [ADDR_W-1:0]  slot_waddr;
	logic               slot_re;
	logic [ADDR_W-1:0]  slot_raddr;
	logic [ENTRY_W-1:0] slot_rdata;
	logic [NICE_W-1:0]  rd_nice;
	logic [TAG_W-1:0]   rd_tag;

	logic               is_ins;
	logic               is_try;
	logic               is_rst;
	logic               kind_ok;
	logic               below;
	logic               append;
	logic               win;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg.valid) begin
			limit_q <= cfg.data;
		end
	end

	always_comb begin
		if (32'(limit_q) < 32'(SLOTS)) begin
			lim_eff = FILL_W'(limit_q);
		end else begin
			lim_eff = SLOTS_F;
		end
	end

	assign is_ins  = (act_q == ACT_INSERT);
	assign is_try  = (act_q == ACT_TRY);
	assign is_rst  = (act_q == ACT_RESET);
	assign kind_ok = (kind_q == KIND_USER) || (kind_q == KIND_HIGH);
	assign below   = (fill_q < lim_eff);
	assign append  = ((is_ins && kind_ok) || is_try) && below;
	assign win     = $signed(worst_nice_q) > $signed(nice_q);

	assign rd_nice = slot_rdata[ENTRY_W-1 -: NICE_W];
	assign rd_tag  = slot_rdata[TAG_W-1:0];

	assign sts.clr_done  = cmd.clr_en && (clr_cnt_q == USER_W'(USERS - 1));
	assign sts.need_scan = is_ins && kind_ok && !below && (fill_q != '0);
	assign sts.scan_done = cmp_vld_s1 && (FILL_W'(cmp_idx_s1) == (fill_q - FILL_W'(1)));
	assign sts.out_free  = !out_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_en) begin
			clr_cnt_q <= clr_cnt_q + USER_W'(1);
		end
	end

	assign fill_we    = cmd.clr_en || (cmd.decide && (append || is_rst));
	assign fill_waddr = cmd.clr_en ? clr_cnt_q : user_q;
	assign fill_wdata = (cmd.decide && append) ? (fill_q + FILL_W'(1)) : '0;

	pua_ram #(
		.WIDTH (FILL_W),
		.DEPTH (USERS)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.re    (cmd.latch),
		.raddr (USER_LUT[item.user_id]),
		.rdata (fill_rdata)
	);

	assign slot_we    = (cmd.decide && append) || (cmd.evict && win);
	assign slot_waddr = cmd.evict ? (base_q + ADDR_W'(worst_idx_q)) : (base_q + ADDR_W'(fill_q));
	assign slot_re    = cmd.scan_en && (scan_rd_q < fill_q);
	assign slot_raddr = base_q + ADDR_W'(scan_rd_q);

	pua_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (USERS * SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata ({nice_q, tag_q}),
		.re    (slot_re),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			act_q  <= item.action;
			user_q <= USER_LUT[item.user_id];
			tag_q  <= item.request_id;
			kind_q <= item.request_kind;
			nice_q <= item.priority_nice;
		end
		if (cmd.fill_cap) begin
			fill_q <= (fill_rdata > SLOTS_F) ? SLOTS_F : fill_rdata;
			base_q <= ADDR_W'(user_q) * ADDR_W'(SLOTS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_rd_q  <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= slot_re;
			if (cmd.decide) begin
				scan_rd_q <= '0;
			end else if (slot_re) begin
				scan_rd_q <= scan_rd_q + FILL_W'(1);
			end
		end
	end

	assign worst_upd = cmp_vld_s1
		&& ((cmp_idx_s1 == '0) || ($signed(rd_nice) > $signed(worst_nice_q)));

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= SLOT_W'(scan_rd_q);
		if (worst_upd) begin
			worst_idx_q  <= cmp_idx_s1;
			worst_nice_q <= rd_nice;
			worst_tag_q  <= rd_tag;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			res_ev_q   <= 1'b0;
			res_tag_q  <= '0;
			res_free_q <= (is_try && below) ? FREE_W'(lim_eff - fill_q - FILL_W'(1)) : '0;
			if (append) begin
				res_status_q <= STAT_DISPATCH;
			end else if (is_ins) begin
				res_status_q <= STAT_QUEUED;
			end else if (is_rst) begin
				res_status_q <= STAT_CLEARED;
			end else begin
				res_status_q <= STAT_REJECT;
			end
		end else if (cmd.evict) begin
			res_free_q <= '0;
			if (win) begin
				res_status_q <= STAT_DISPATCH;
				res_ev_q     <= 1'b1;
				res_tag_q    <= worst_tag_q;
			end else begin
				res_status_q <= STAT_QUEUED;
				res_ev_q     <= 1'b0;
				res_tag_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_ev_q     <= res_ev_q;
			out_tag_q    <= res_tag_q;
			out_free_q   <= res_free_q;
		end
	end

	assign rsp.valid              = out_vld_q;
	assign rsp.status             = out_status_q;
	assign rsp.evicted_valid      = out_ev_q;
	assign rsp.evicted_request_id = out_tag_q;
	assign rsp.free_slots         = out_free_q;
endmodule
`default_nettype wire

// ===== design/per_user_priority_admission_top.sv =====
`default_nettype none
// Per-user priority admission: one response per request transaction, one
// transaction in flight at a time. A try-immediate, a bucket reset, or an insert
// that finds room or needs no eviction passes from acceptance through the fill,
// decide and done states. An insert into a full bucket also scans the held
// entries through the single read port of the slot memory, one entry per cycle,
// and then passes through an evict state. The response sits in an output
// register, so the next request is taken while it waits. After reset a clearing
// pass writes zero into the fill-count memory, one user per cycle, for all
// USERS (256) users before the first request is taken. The configuration port
// is always ready; write bucket_limit only while no request is in flight.
module per_user_priority_admission_top (
	input  logic      clk,
	input  logic      arst_n,
	pua_req_if.sink   req,
	pua_rsp_if.source rsp,
	pua_cfg_if.sink   cfg
);
	import pua_pkg::*;

	pua_item_t item;
	pua_cmd_t  cmd;
	pua_sts_t  sts;
	logic      req_ready;

	assign item.action        = req.action;
	assign item.user_id       = req.user_id;
	assign item.request_id    = req.request_id;
	assign item.request_kind  = req.request_kind;
	assign item.priority_nice = req.priority_nice;
	assign req.ready          = req_ready;

	pua_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pua_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.cfg    (cfg),
		.rsp    (rsp)
	);
endmodule
`default_nettype wire

// ===== design/pua_checker.sv =====
`default_nettype none
module pua_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic        rsp_evicted_valid,
	input logic [15:0] rsp_evicted_request_id,
	input logic [3:0]  rsp_free_slots
);
	import pua_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response transaction dropped while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in flight");

	a_evict_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_evicted_valid |-> rsp_status == STAT_DISPATCH)
		else $error("eviction without dispatch");

	a_evict_tag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_evicted_valid |-> rsp_evicted_request_id == 16'd0)
		else $error("evicted tag set without eviction");

	a_free_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_free_slots != 4'd0) |->
			(rsp_status == STAT_DISPATCH) && !rsp_evicted_valid)
		else $error("free slots reported outside immediate admission");
endmodule

bind per_user_priority_admission_top pua_checker u_pua_checker (
	.clk                    (clk),
	.arst_n                 (arst_n),
	.req_valid              (req.valid),
	.req_ready              (req.ready),
	.rsp_valid              (rsp.valid),
	.rsp_ready              (rsp.ready),
	.rsp_status             (rsp.status),
	.rsp_evicted_valid      (rsp.evicted_valid),
	.rsp_evicted_request_id (rsp.evicted_request_id),
	.rsp_free_slots         (rsp.free_slots)
);
`default_nettype wire

// ===== tb/per_user_priority_admission_top_test.sv =====
`timescale 1ns / 1ps
module per_user_priority_admission_top_test;
	import pua_pkg::*;

	localparam logic [1:0] ACT_UNDEFINED = 2'd3;
	localparam logic [1:0] KIND_OTHER = 2'd2;
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;
	localparam int PHASE_ITEMS = 180;
	localparam int STREAM_ITEMS = 400;
	localparam int DRAIN_CYCLES = 16;
	localparam int QUIET_LIMIT = 2000;

	typedef struct packed {
		logic [1:0] status;
		logic evicted_valid;
		logic [15:0] evicted_request_id;
		logic [3:0] free_slots;
	} admission_result_t;

	logic clk = 1'b0;
	logic arst_n;

	pua_req_if req();
	pua_rsp_if rsp();
	pua_cfg_if cfg();

	per_user_priority_admission_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [3:0] bucket_limit_q;
	int unsigned held_count [USERS];
	logic signed [7:0] held_nice [USERS][SLOTS];
	logic [15:0] held_tag [USERS][SLOTS];
	admission_result_t pending_results [$];
	admission_result_t oldest_result;
	logic [7:0] hot_users [4];

	bit req_gaps_on = 1'b0;
	bit rsp_stalls_on = 1'b0;
	int mismatches = 0;
	int requests_sent = 0;
	int responses_seen = 0;
	int limits_written = 0;
	int n_dispatch = 0;
	int n_preempt = 0;
	int n_queued = 0;
	int n_reject = 0;
	int n_cleared = 0;
	int unsigned quiet_cycles = 0;

	function automatic admission_result_t predict_admission(pua_item_t rq);
		admission_result_t res;
		int unsigned u;
		int unsigned lim;
		int unsigned fill;
		int unsigned worst;
		logic signed [7:0] worst_nice;
		logic signed [7:0] new_nice;
		res = '0;
		res.status = STAT_REJECT;
		u = rq.user_id % USERS;
		lim = (bucket_limit_q < SLOTS) ? bucket_limit_q : SLOTS;
		fill = (held_count[u] > SLOTS) ? SLOTS : held_count[u];
		new_nice = $signed(rq.priority_nice);
		case (rq.action)
			ACT_INSERT: begin
				if (rq.request_kind == KIND_USER || rq.request_kind == KIND_HIGH) begin
					if (fill < lim) begin
						held_nice[u][fill] = new_nice;
						held_tag[u][fill] = rq.request_id;
						held_count[u] = fill + 1;
						res.status = STAT_DISPATCH;
					end else if (fill == 0) begin
						res.status = STAT_QUEUED;
					end else begin
						worst = 0;
						worst_nice = held_nice[u][0];
						for (int s = 1; s < fill; s++) begin
							if (held_nice[u][s] > worst_nice) begin
								worst_nice = held_nice[u][s];
								worst = s;
							end
						end
						if (worst_nice > new_nice) begin
							res.evicted_valid = 1'b1;
							res.evicted_request_id = held_tag[u][worst];
							held_nice[u][worst] = new_nice;
							held_tag[u][worst] = rq.request_id;
							res.status = STAT_DISPATCH;
						end else begin
							res.status = STAT_QUEUED;
						end
					end
				end else begin
					res.status = STAT_QUEUED;
				end
			end
			ACT_TRY: begin
				if (fill < lim) begin
					held_nice[u][fill] = new_nice;
					held_tag[u][fill] = rq.request_id;
					held_count[u] = fill + 1;
					res.free_slots = 4'(lim - (fill + 1));
					res.status = STAT_DISPATCH;
				end
			end
			ACT_RESET: begin
				held_count[u] = 0;
				res.status = STAT_CLEARED;
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic send_request(input logic [1:0] act, input logic [7:0] user,
			input logic [15:0] tag, input logic [1:0] kind, input logic [7:0] nice);
		pua_item_t rq;
		admission_result_t res;
		rq.action = act;
		rq.user_id = user;
		rq.request_id = tag;
		rq.request_kind = kind;
		rq.priority_nice = nice;
		@(negedge clk);
		req.valid = 1'b1;
		req.action = act;
		req.user_id = user;
		req.request_id = tag;
		req.request_kind = kind;
		req.priority_nice = nice;
		do @(posedge clk); while (req.ready !== 1'b1);
		res = predict_admission(rq);
		pending_results = {pending_results, res};
		requests_sent++;
		case (res.status)
			STAT_DISPATCH: n_dispatch++;
			STAT_QUEUED: n_queued++;
			STAT_REJECT: n_reject++;
			default: n_cleared++;
		endcase
		if (res.evicted_valid)
			n_preempt++;
	endtask

	task automatic sender_gap();
		int n;
		n = $urandom_range(1, 6);
		repeat (n) begin
			@(negedge clk);
			req.valid = 1'b0;
		end
	endtask

	task automatic wait_until_drained();
		@(negedge clk);
		req.valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_bucket_limit(input logic [3:0] value);
		wait_until_drained();
		@(negedge clk);
		cfg.valid = 1'b1;
		cfg.data = value;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		bucket_limit_q = value;
		limits_written++;
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	task automatic send_random_request();
		logic [1:0] act;
		logic [1:0] kind;
		logic [7:0] user;
		logic [7:0] nice;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			act = ACT_INSERT;
		else if (roll < 85)
			act = ACT_TRY;
		else if (roll < 93)
			act = ACT_RESET;
		else
			act = ACT_UNDEFINED;
		if ($urandom_range(0, 6) == 0)
			user = 8'($urandom_range(0, 255));
		else
			user = hot_users[$urandom_range(0, 3)];
		if ($urandom_range(0, 6) == 0)
			kind = 2'($urandom_range(KIND_OTHER, KIND_UNKNOWN));
		else
			kind = 2'($urandom_range(KIND_USER, KIND_HIGH));
		if ($urandom_range(0, 1) == 0)
			nice = 8'($urandom_range(0, 255));
		else
			nice = 8'(int'($urandom_range(0, 6)) - 3);
		send_request(act, user, 16'($urandom_range(0, 65535)), kind, nice);
	endtask

	task automatic pick_hot_users();
		for (int h = 0; h < 4; h++)
			hot_users[h] = 8'($urandom_range(0, 255));
	endtask

	task automatic test_preemption();
		logic [7:0] nice;
		send_request(ACT_TRY, 8'd3, 16'h0000, KIND_UNKNOWN, 8'h80);
		for (int s = 0; s < 8; s++) begin
			if (s == 1)
				nice = 8'h80;
			else if (s == 3 || s == 5)
				nice = 8'(s);
			else
				nice = 8'h7F;
			send_request(ACT_INSERT, 8'd255, (s == 0) ? 16'hFFFF : 16'(s),
				(s % 2 == 0) ? KIND_USER : KIND_HIGH, nice);
		end
		send_request(ACT_INSERT, 8'd255, 16'h00A0, KIND_HIGH, 8'd126);
		send_request(ACT_INSERT, 8'd255, 16'h00A1, KIND_USER, 8'h7F);
		send_request(ACT_INSERT, 8'd255, 16'h00A2, KIND_OTHER, 8'h80);
		send_request(ACT_INSERT, 8'd255, 16'h00A3, KIND_UNKNOWN, 8'h80);
		send_request(ACT_TRY, 8'd255, 16'h00A4, KIND_USER, 8'h80);
		send_request(ACT_UNDEFINED, 8'd255, 16'hFFFF, KIND_UNKNOWN, 8'h7F);
	endtask

	task automatic test_limit_settings();
		write_bucket_limit(4'd2);
		send_request(ACT_INSERT, 8'd255, 16'h5555, KIND_USER, 8'h80);
		send_request(ACT_TRY, 8'd255, 16'h5556, KIND_USER, 8'd0);
		send_request(ACT_TRY, 8'd13, 16'h5557, KIND_HIGH, 8'd0);
		write_bucket_limit(4'd0);
		send_request(ACT_INSERT, 8'd10, 16'h1000, KIND_USER, 8'h80);
		send_request(ACT_TRY, 8'd10, 16'h1001, KIND_HIGH, 8'h80);
		write_bucket_limit(4'd15);
		send_request(ACT_TRY, 8'd11, 16'h1100, KIND_OTHER, 8'd1);
		write_bucket_limit(4'd1);
		send_request(ACT_INSERT, 8'd14, 16'h1400, KIND_USER, 8'd50);
		send_request(ACT_INSERT, 8'd14, 16'h1401, KIND_HIGH, 8'hCE);
		send_request(ACT_RESET, 8'd255, 16'h0000, KIND_USER, 8'd0);
		send_request(ACT_INSERT, 8'd255, 16'h2550, KIND_USER, 8'd0);
	endtask

	task automatic test_random_traffic();
		logic [3:0] lim;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: lim = 4'd8;
				1: lim = 4'd3;
				2: lim = 4'd1;
				3: lim = 4'd15;
				4: lim = 4'd5;
				5: lim = 4'd0;
				6: lim = 4'd2;
				default: lim = 4'd9;
			endcase
			write_bucket_limit(lim);
			pick_hot_users();
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 50 == 0) begin
					req_gaps_on = ($urandom_range(0, 3) != 0);
					rsp_stalls_on = ($urandom_range(0, 3) != 0);
				end
				send_random_request();
				if (req_gaps_on && $urandom_range(0, 3) == 0)
					sender_gap();
				if ($urandom_range(0, 79) == 0)
					wait_until_drained();
			end
		end
	endtask

	task automatic test_back_to_back();
		write_bucket_limit(4'd4);
		req_gaps_on = 1'b0;
		rsp_stalls_on = 1'b0;
		pick_hot_users();
		for (int i = 0; i < STREAM_ITEMS; i++)
			send_random_request();
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h",
				$time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			responses_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t ns: response, expected none, actual status %0d",
					$time, rsp.status);
			end else begin
				oldest_result = pending_results.pop_front();
				check_field("status", 16'(oldest_result.status), 16'(rsp.status));
				check_field("evicted_valid", 16'(oldest_result.evicted_valid),
					16'(rsp.evicted_valid));
				check_field("evicted_request_id", oldest_result.evicted_request_id,
					rsp.evicted_request_id);
				check_field("free_slots", 16'(oldest_result.free_slots),
					16'(rsp.free_slots));
			end
		end
	end

	always begin
		@(negedge clk);
		if (rsp_stalls_on && $urandom_range(0, 5) == 0) begin
			rsp.ready = 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
		end else begin
			rsp.ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)
				|| (cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t ns: no transaction for %0d cycles", $time, quiet_cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.action = ACT_INSERT;
		req.user_id = '0;
		req.request_id = '0;
		req.request_kind = KIND_USER;
		req.priority_nice = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		bucket_limit_q = LIMIT_RESET;
		for (int u = 0; u < USERS; u++)
			held_count[u] = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_preemption();
		test_limit_settings();
		test_random_traffic();
		test_back_to_back();

		wait_until_drained();
		repeat (20) @(posedge clk);
		$display("Ran %0d requests (%0d responses) over %0d bucket_limit writes",
			requests_sent, responses_seen, limits_written);
		$display("Outcomes: %0d dispatched, %0d preemptions, %0d queued, %0d rejected, %0d cleared.",
			n_dispatch, n_preempt, n_queued, n_reject, n_cleared);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
